### src/assert_macros.svh
// Assertion macros used by the key cache top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LKC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define LKC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

### src/lkc_pkg.sv
// Shared constants and types for the LRU key cache.
package lkc_pkg;

    localparam int KEY_W               = 32;
    localparam int CAP_W               = 5;
    localparam int DEFAULT_MAX_ENTRIES = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd4;

    // Data handed from one cell to the next one back in recency order.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             valid;
        logic             shift;
    } t_link;

    // Control broadcast to every cell.
    typedef struct packed {
        logic step;
        logic clear;
    } t_cell_ctrl;

endpackage

### src/lru_key_cache_hit_tracker.sv
// Top level of the fully associative LRU key cache with hit reporting.
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   busy is always low, so one key may be presented in every cycle.
//   Each request yields one result: o_hit_valid pulses for one cycle, in the
//   cycle after the request, with o_hit set if the key was already held.
//   The receiver cannot stall; results must be taken as they appear.
//   Throughput is one request per cycle. The slot chain compares every slot
//   against the key and shifts slots back in the same cycle, so the ripple
//   of the shift enable through the row of cells sets the cycle time.
//   Writing i_cfg_capacity with i_cfg_we sets the capacity (0 acts as 1,
//   values above MAX_ENTRIES act as MAX_ENTRIES) and empties the store.
//   Write it only while no request is in flight.
//   Reset (i_rst_n low, synchronous) empties the store, sets the capacity
//   to 4 and drops any pending result.
module lru_key_cache_hit_tracker #(
    parameter int MAX_ENTRIES = lkc_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [lkc_pkg::KEY_W-1:0]  i_key,
    input  logic                              i_cfg_we,
    input  logic [lkc_pkg::CAP_W-1:0]         i_cfg_capacity,
    output logic                              o_hit_valid,
    output logic                              o_hit
);

    `include "assert_macros.svh"

    localparam int CNT_W = ($clog2(MAX_ENTRIES + 1) > lkc_pkg::CAP_W) ?
                           $clog2(MAX_ENTRIES + 1) : lkc_pkg::CAP_W;

    logic [lkc_pkg::CAP_W-1:0] r_capacity;
    logic [CNT_W-1:0]          w_cap_wide;
    logic [CNT_W-1:0]          w_eff_cap;
    logic                      r_hit_valid;
    logic                      r_hit;
    logic                      w_accept;
    lkc_pkg::t_cell_ctrl       w_ctrl;
    lkc_pkg::t_link            w_link [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0]    w_match;
    logic [MAX_ENTRIES-1:0]    w_valid;
    logic [MAX_ENTRIES-1:0]    w_in_cap;

    // The chain never stalls, so busy is tied low.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkc_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_capacity;
        end
    end

    // Effective capacity: at least one slot, at most the size of the chain.
    assign w_cap_wide = CNT_W'(r_capacity);
    always_comb begin
        if (w_cap_wide == '0) begin
            w_eff_cap = CNT_W'(1);
        end else if (w_cap_wide > CNT_W'(MAX_ENTRIES)) begin
            w_eff_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            w_eff_cap = w_cap_wide;
        end
    end

    // Broadcast control to the cells.
    assign w_ctrl.step  = w_accept;
    assign w_ctrl.clear = i_cfg_we;

    // The head of the chain receives the requested key.
    assign w_link[0].key   = i_key;
    assign w_link[0].valid = 1'b1;
    assign w_link[0].shift = 1'b1;

    // Row of cells, most recent first.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        assign w_in_cap[g] = (CNT_W'(g) < w_eff_cap);

        lkc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_search (i_key),
            .i_in_cap (w_in_cap[g]),
            .i_link   (w_link[g]),
            .o_link   (w_link[g+1]),
            .o_match  (w_match[g]),
            .o_valid  (w_valid[g])
        );
    end

    // Result register: one strobe per accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_valid <= 1'b0;
        end else begin
            r_hit_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit <= |w_match;
        end
    end

    assign o_hit_valid = r_hit_valid;
    assign o_hit       = r_hit;

    // A held key lives in exactly one slot.
    `LKC_ASSERT_IMPL(a_single_match, 1'b1, $onehot0(w_match))
    // Valid slots form a run starting at the head of the chain.
    `LKC_ASSERT_IMPL(a_valid_run, 1'b1, ((w_valid >> 1) & ~w_valid) == '0)
    // Every accepted request produces a result in the next cycle.
    `LKC_ASSERT_NEXT(a_result_follows, w_accept, o_hit_valid)
    // A capacity write empties the store.
    `LKC_ASSERT_NEXT(a_cfg_clears, i_cfg_we && !w_accept, w_valid == '0)

endmodule

### src/lkc_cell.sv
// One slot of the recency chain: holds a key, compares it and shifts it back.
module lkc_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lkc_pkg::t_cell_ctrl            i_ctrl,
    input  logic [lkc_pkg::KEY_W-1:0]      i_search,
    input  logic                           i_in_cap,
    input  lkc_pkg::t_link                 i_link,
    output lkc_pkg::t_link                 o_link,
    output logic                           o_match,
    output logic                           o_valid
);

    logic [lkc_pkg::KEY_W-1:0] r_key;
    logic                      r_valid;
    logic                      w_shift;

    // Compare the held key against the key of the current request.
    assign o_match = r_valid && (r_key == i_search);
    assign o_valid = r_valid;

    // In capacity, a slot takes its neighbor's key if no slot ahead matched.
    assign w_shift = i_link.shift && i_in_cap;

    // Hand the current contents back to the next slot.
    assign o_link.key   = r_key;
    assign o_link.valid = r_valid;
    assign o_link.shift = w_shift && !o_match;

    // Valid bit is control state and is cleared by reset or a capacity write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.step && w_shift) begin
            r_valid <= i_link.valid;
        end
    end

    // Key storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step && w_shift) begin
            r_key <= i_link.key;
        end
    end

endmodule
